### rtl/lld_pkg.sv
package lld_pkg;

  // Size of the design.
  localparam int NUM_CORES    = 8;
  localparam int QUEUE_DEPTH  = 64;
  localparam int HANDLE_WIDTH = 16;

  // Fixed field widths at the ports.
  localparam int CORE_FIELD_W  = 3;
  localparam int HANDLE_PORT_W = 16;
  localparam int DEPTH_PORT_W  = 6;
  localparam int MASK_W        = 8;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 8;

  // Derived widths.
  localparam int CORE_W     = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = PTR_W;
  localparam int SLOT_COUNT = NUM_CORES * QUEUE_DEPTH;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef logic [CORE_FIELD_W-1:0] core_t;
  typedef logic [CORE_W-1:0]       core_idx_t;
  typedef logic [HANDLE_WIDTH-1:0] handle_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  // A ring keeps one slot free, so it is full at one entry short of its size.
  localparam cnt_t FULL_CNT = CNT_W'(QUEUE_DEPTH - 1);

  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SERVICE_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ONLINE_MASK  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_CORE    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SLOT    = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_POP_EMPTY,
    OP_NO_SLOT,
    OP_BAD_HANDLE
  } cmd_op_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  typedef struct packed {
    logic [MASK_W-1:0] service_mask;
    logic [MASK_W-1:0] online_mask;
    core_t             boot_core;
  } cfg_t;

  typedef struct packed {
    cmd_op_t op;
    core_t   core;
    handle_t handle;
    cnt_t    depth;
  } cmd_t;

  typedef struct packed {
    status_t                   status;
    core_t                     core;
    logic [HANDLE_PORT_W-1:0]  handle;
    logic [DEPTH_PORT_W-1:0]   depth;
    logic                      wake;
  } result_t;

  function automatic logic core_present(core_t c);
    return int'(c) < NUM_CORES;
  endfunction

  function automatic ptr_t next_ptr(ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic addr_t slot_addr(core_idx_t c, ptr_t p);
    return ADDR_W'(int'(c) * QUEUE_DEPTH + int'(p));
  endfunction

endpackage

### rtl/lld_ram.sv
module lld_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lld_front.sv
module lld_front
  import lld_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            action,
  input  core_t                           core_index,
  input  logic [HANDLE_PORT_W-1:0]        work_handle,
  input  cfg_t                            cfg,
  input  logic [NUM_CORES-1:0][CNT_W-1:0] counts,
  input  logic                            q_full,
  output logic                            q_push,
  output cmd_t                            q_cmd
);

  logic    item_valid;
  logic    it_action;
  core_t   it_core;
  handle_t it_handle;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (q_push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_action <= action;
      it_core   <= core_index;
      it_handle <= HANDLE_WIDTH'(work_handle);
    end
  end

  assign q_push = item_valid && !q_full;

  // Classification of a submit: least-loaded online service core, else the boot core,
  // and the first other service core with room when that choice is full.
  always_comb begin
    logic  found;
    cnt_t  best;
    core_t target;
    logic  tgt_ok;
    logic  alt_found;
    core_t alt;
    cnt_t  tgt_depth;
    found     = 1'b0;
    best      = '0;
    target    = cfg.boot_core;
    alt_found = 1'b0;
    alt       = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      if (cfg.service_mask[i] && cfg.online_mask[i] && (!found || counts[i] < best)) begin
        found  = 1'b1;
        best   = counts[i];
        target = CORE_FIELD_W'(i);
      end
    end
    tgt_ok    = core_present(target) && (counts[target[CORE_W-1:0]] != FULL_CNT);
    tgt_depth = core_present(target) ? counts[target[CORE_W-1:0]] : '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      if (!alt_found && cfg.service_mask[i] && (CORE_FIELD_W'(i) != target) &&
          (counts[i] != FULL_CNT)) begin
        alt_found = 1'b1;
        alt       = CORE_FIELD_W'(i);
      end
    end

    q_cmd.handle = it_handle;
    q_cmd.depth  = '0;
    q_cmd.core   = it_core;
    q_cmd.op     = OP_POP_EMPTY;
    if (it_action == ACT_POP) begin
      if (core_present(it_core) && (counts[it_core[CORE_W-1:0]] != '0)) begin
        q_cmd.op = OP_POP;
      end
    end else if (it_handle == '0) begin
      q_cmd.op   = OP_BAD_HANDLE;
      q_cmd.core = '0;
    end else if (tgt_ok) begin
      q_cmd.op   = OP_PUSH;
      q_cmd.core = target;
    end else if (alt_found) begin
      q_cmd.op   = OP_PUSH;
      q_cmd.core = alt;
    end else begin
      q_cmd.op    = OP_NO_SLOT;
      q_cmd.core  = target;
      q_cmd.depth = tgt_depth;
    end
  end

endmodule

### rtl/lld_queue.sv
module lld_queue
  import lld_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t head_cmd
);

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] fill;

  assign full     = (fill == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid    = (fill != '0);
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CMDQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + CMDQ_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CMDQ_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CMDQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/lld_back.sv
module lld_back
  import lld_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  cmd_t                            q_cmd,
  output logic                            q_pop,
  output logic [NUM_CORES-1:0][CNT_W-1:0] counts,
  output logic                            res_valid,
  output result_t                         res
);

  back_state_t state;
  back_state_t state_next;
  ptr_t        heads [NUM_CORES];
  ptr_t        tails [NUM_CORES];
  core_idx_t   idx;
  cnt_t        cnt_cur;
  cnt_t        pend_depth;
  core_t       pend_core;
  logic        ram_we;
  addr_t       ram_waddr;
  addr_t       ram_raddr;
  handle_t     ram_rdata;
  result_t     res_next;

  assign idx     = q_cmd.core[CORE_W-1:0];
  assign cnt_cur = counts[idx];

  lld_ram #(
    .WIDTH(HANDLE_WIDTH),
    .DEPTH(SLOT_COUNT)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(q_cmd.handle),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid && q_cmd.op == OP_POP) begin
          state_next = BK_READ;
        end
      end
      BK_READ: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == BK_IDLE) && q_valid;
    ram_we    = q_pop && (q_cmd.op == OP_PUSH);
    ram_waddr = slot_addr(idx, tails[idx]);
    ram_raddr = slot_addr(idx, heads[idx]);
  end

  // Result of the command in hand: a pop finishes once the slot read is back.
  always_comb begin
    res_next = '0;
    if (state == BK_READ) begin
      res_next.status = ST_OK;
      res_next.core   = pend_core;
      res_next.handle = HANDLE_PORT_W'(ram_rdata);
      res_next.depth  = DEPTH_PORT_W'(pend_depth);
      res_next.wake   = 1'b0;
    end else begin
      res_next.core   = q_cmd.core;
      res_next.handle = '0;
      res_next.depth  = '0;
      res_next.wake   = 1'b0;
      case (q_cmd.op)
        OP_PUSH: begin
          res_next.status = ST_OK;
          res_next.depth  = DEPTH_PORT_W'(cnt_cur + CNT_W'(1));
          res_next.wake   = 1'b1;
        end
        OP_NO_SLOT: begin
          res_next.status = ST_NO_SLOT;
          res_next.depth  = DEPTH_PORT_W'(q_cmd.depth);
        end
        OP_BAD_HANDLE: begin
          res_next.status = ST_BAD_HANDLE;
          res_next.core   = '0;
        end
        default: begin
          res_next.status = ST_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_CORES; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      state     <= state_next;
      res_valid <= (state == BK_READ) || (q_pop && q_cmd.op != OP_POP);
      if (q_pop && q_cmd.op == OP_PUSH) begin
        tails[idx]  <= next_ptr(tails[idx]);
        counts[idx] <= cnt_cur + CNT_W'(1);
      end
      if (q_pop && q_cmd.op == OP_POP) begin
        heads[idx]  <= next_ptr(heads[idx]);
        counts[idx] <= cnt_cur - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == OP_POP) begin
      pend_core  <= q_cmd.core;
      pend_depth <= cnt_cur - CNT_W'(1);
    end
    if ((state == BK_READ) || q_pop) begin
      res <= res_next;
    end
  end

endmodule

### rtl/least_loaded_queue_dispatch.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// item in  | start, busy         | action, core_index, work_handle
// result   | done (1-cycle pulse)| status, target_core, popped_handle,
//          |                     | queue_depth, wake
// config   | cfg_we              | cfg_index, cfg_data
//
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been shown. Each item passes through the front end,
// which latches and classifies it, then the command queue, then the back
// end; on a pop the back end also waits in its read state for the slot
// RAM's registered read. The result sits on its ports for one cycle with
// done high and cannot be held off. Reset (rst, synchronous) empties all
// rings and clears the masks and boot core; slot contents are not cleared.
module least_loaded_queue_dispatch
  import lld_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     action,
  input  logic [CORE_FIELD_W-1:0]  core_index,
  input  logic [HANDLE_PORT_W-1:0] work_handle,
  input  logic                     cfg_we,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output logic                     done,
  output logic [1:0]               status,
  output logic [CORE_FIELD_W-1:0]  target_core,
  output logic [HANDLE_PORT_W-1:0] popped_handle,
  output logic [DEPTH_PORT_W-1:0]  queue_depth,
  output logic                     wake
);

  cfg_t                            cfg;
  logic                            accept;
  logic                            q_push;
  logic                            q_full;
  logic                            q_valid;
  logic                            q_pop;
  cmd_t                            push_cmd;
  cmd_t                            head_cmd;
  logic [NUM_CORES-1:0][CNT_W-1:0] counts;
  logic                            res_valid;
  result_t                         res;

  assign accept = start && !busy;

  // Configuration registers. Write only while no item is in flight, so the
  // front end classifies with settled masks; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SERVICE_MASK: cfg.service_mask <= cfg_data;
        CFG_ONLINE_MASK:  cfg.online_mask  <= cfg_data;
        CFG_BOOT_CORE:    cfg.boot_core    <= CORE_FIELD_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // One item is in flight at a time: busy covers the item from its
  // acceptance to the cycle in which its result is shown. The ring counts
  // that the front end reads are therefore always up to date.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (res_valid) begin
      busy <= 1'b0;
    end
  end

  // Front end: latches the item and picks the operation and target core.
  lld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (action),
    .core_index (core_index),
    .work_handle(work_handle),
    .cfg        (cfg),
    .counts     (counts),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  // Short command queue between classification and execution.
  lld_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .head_cmd(head_cmd)
  );

  // Back end: owns the rings (pointers, counts, slot RAM) and forms results.
  lld_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .q_pop    (q_pop),
    .counts   (counts),
    .res_valid(res_valid),
    .res      (res)
  );

  assign done          = res_valid;
  assign status        = res.status;
  assign target_core   = res.core;
  assign popped_handle = res.handle;
  assign queue_depth   = res.depth;
  assign wake          = res.wake;

  // A result only appears for an item that is in flight.
  a_done_in_flight: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown with no item in flight");

  // No item finishes in the cycle right after it was taken.
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> !done)
    else $error("result appeared one cycle after acceptance");

  // Only a successful submit wakes a core.
  a_wake_ok: assert property (@(posedge clk) disable iff (rst)
    (done && wake) |-> (status == ST_OK && popped_handle == '0))
    else $error("wake raised on a result that is not a successful submit");

  // Failed items give back no handle and wake nobody.
  a_fail_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (!wake && popped_handle == '0))
    else $error("failed item carries a handle or a wake");

endmodule
